/* sv/ffsa_pkg.sv */
// Shared types and constants for the first-fit slot allocator.
// Holds status codes, controller states, register indexes and the
// command/status bundles between controller and datapath. No dependencies.
package ffsa_pkg;

    // Field and register widths
    localparam int ROW_W      = 4;
    localparam int COL_W      = 7;
    localparam int LEN_W      = 8;
    localparam int POOL_W     = 6;
    localparam int RIU_W      = 5;
    localparam int CIU_W      = 8;
    localparam int PCNT_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_COUNT  = 2'd2;

    // Register reset values
    localparam logic [RIU_W-1:0]  RIU_RESET  = 5'd16;
    localparam logic [CIU_W-1:0]  CIU_RESET  = 8'd128;
    localparam logic [PCNT_W-1:0] PCNT_RESET = 7'd1;
    localparam logic [PCNT_W-1:0] MAX_POOLS  = 7'd64;

    typedef enum logic [1:0] {
        STAT_PLACED       = 2'd0,
        STAT_NO_FIT       = 2'd1,
        STAT_MARKED       = 2'd2,
        STAT_OUT_OF_RANGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MARK_WR,
        S_SCAN,
        S_ALLOC_WR,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic    capture;
        logic    mark_rd;
        logic    mark_wr;
        logic    scan_start;
        logic    scan_run;
        logic    alloc_wr;
        logic    load_out;
        status_t code;
    } ffsa_cmd_t;

    typedef struct packed {
        logic req_alloc;
        logic mark_ok;
        logic alloc_ok;
        logic hit;
        logic scan_done;
        logic out_busy;
    } ffsa_stat_t;

endpackage

/* sv/ffsa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/ffsa_dp.sv */
// Datapath of the slot allocator: config registers, request capture, bitmap RAM,
// row scan pipeline, run search, pool counter and result register.
// Depends on ffsa_pkg and ffsa_ram.
module ffsa_dp
    import ffsa_pkg::*;
#(
    parameter int ROWS = 16,
    parameter int COLS = 128
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  req_type,
    input  logic [ROW_W-1:0]      slot_row,
    input  logic [COL_W-1:0]      slot_col,
    input  logic [LEN_W-1:0]      run_length,
    input  ffsa_cmd_t             cmd,
    output ffsa_stat_t            stat,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic [1:0]            status,
    output logic [ROW_W-1:0]      grant_row,
    output logic [COL_W-1:0]      grant_col,
    output logic [POOL_W-1:0]     pool
);

    // Only rows reachable by a 5-bit row count and columns reachable by an
    // 8-bit column count are ever touched.
    localparam int NROW = (ROWS < 31) ? ROWS : 31;
    localparam int NCOL = (COLS < 255) ? COLS : 255;
    localparam int RAW  = (NROW > 1) ? $clog2(NROW) : 1;
    localparam int CW   = (NCOL > 1) ? $clog2(NCOL) : 1;
    localparam int NSTEP = LEN_W;
    localparam logic [RIU_W-1:0] NROW_LIM = RIU_W'(NROW);
    localparam logic [CIU_W-1:0] NCOL_LIM = CIU_W'(NCOL);

    // Configuration
    logic [RIU_W-1:0]  rows_in_use_reg;
    logic [CIU_W-1:0]  cols_in_use_reg;
    logic [PCNT_W-1:0] pool_count_reg;
    logic [RIU_W-1:0]  nr;
    logic [CIU_W-1:0]  nc;
    logic [PCNT_W-1:0] eff_pools;

    // Request
    logic              req_type_reg;
    logic [ROW_W-1:0]  req_row_reg;
    logic [COL_W-1:0]  req_col_reg;
    logic [LEN_W-1:0]  req_len_reg;

    // Bitmap storage and per-row written flags
    logic [NROW-1:0]   row_valid_reg;
    logic              ram_we;
    logic [RAW-1:0]    ram_waddr;
    logic [NCOL-1:0]   ram_wdata;
    logic              ram_re;
    logic [RAW-1:0]    ram_raddr;
    logic [NCOL-1:0]   ram_rdata;
    logic              rv1_reg;
    logic [NCOL-1:0]   row_bits;

    // Scan pipeline
    logic [RIU_W-1:0]  cnt_reg;
    logic              issue;
    logic              v1_reg;
    logic [RIU_W-1:0]  row1_reg;
    logic              v2_reg;
    logic [RIU_W-1:0]  row2_reg;
    logic [NCOL-1:0]   win2_reg;
    logic [NCOL-1:0]   data2_reg;

    // Run search
    logic [NCOL-1:0]   q [NSTEP];
    logic [NCOL-1:0]   acc;
    logic              acc_started;
    logic [NCOL-1:0]   win;
    logic [CW-1:0]     end_col;
    logic [CIU_W-1:0]  start_col;
    logic [NCOL-1:0]   run_mask;
    logic [NCOL-1:0]   mark_bit;

    // Pool and grant
    logic [POOL_W-1:0] next_pool_reg;
    logic [PCNT_W-1:0] pool_inc;
    logic [ROW_W-1:0]  g_row_reg;
    logic [COL_W-1:0]  g_col_reg;
    logic [POOL_W-1:0] g_pool_reg;

    // Result register
    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [ROW_W-1:0]  grant_row_reg;
    logic [COL_W-1:0]  grant_col_reg;
    logic [POOL_W-1:0] pool_reg;

    assign nr = (rows_in_use_reg > NROW_LIM) ? NROW_LIM : rows_in_use_reg;
    assign nc = (cols_in_use_reg > NCOL_LIM) ? NCOL_LIM : cols_in_use_reg;
    assign eff_pools = (pool_count_reg == '0) ? PCNT_W'(1) :
                       ((pool_count_reg > MAX_POOLS) ? MAX_POOLS : pool_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg <= RIU_RESET;
            cols_in_use_reg <= CIU_RESET;
            pool_count_reg  <= PCNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROWS_IN_USE: rows_in_use_reg <= cfg_data[RIU_W-1:0];
                CFG_COLS_IN_USE: cols_in_use_reg <= cfg_data[CIU_W-1:0];
                CFG_POOL_COUNT:  pool_count_reg  <= cfg_data[PCNT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg <= req_type;
            req_row_reg  <= slot_row;
            req_col_reg  <= slot_col;
            req_len_reg  <= run_length;
        end
    end

    // Bitmap RAM; rows never written read as all free
    assign issue     = cmd.scan_run && (cnt_reg < nr);
    assign ram_re    = issue || cmd.mark_rd;
    assign ram_raddr = cmd.mark_rd ? RAW'(req_row_reg) : cnt_reg[RAW-1:0];
    assign ram_we    = cmd.mark_wr || cmd.alloc_wr;
    assign ram_waddr = cmd.alloc_wr ? row2_reg[RAW-1:0] : RAW'(req_row_reg);
    assign ram_wdata = cmd.alloc_wr ? (data2_reg | run_mask) : (row_bits | mark_bit);
    assign row_bits  = rv1_reg ? ram_rdata : '0;

    ffsa_ram #(
        .WIDTH (NCOL),
        .DEPTH (NROW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (ram_we)
        begin
            row_valid_reg[ram_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            rv1_reg <= row_valid_reg[ram_raddr];
        end
    end

    // Scan control: one row read issued per cycle, two stages behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            cnt_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
        end
        else if (cmd.scan_run)
        begin
            if (issue)
            begin
                cnt_reg <= cnt_reg + RIU_W'(1);
            end
            v1_reg <= issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_run)
        begin
            row1_reg  <= cnt_reg;
            row2_reg  <= row1_reg;
            win2_reg  <= win;
            data2_reg <= row_bits;
        end
    end

    // Free-run windows: q[i][k] set when the 2**i slots ending at k are free,
    // then combine the windows picked by the bits of the run length. The first
    // window taken stands alone; each later one must follow a free partial run.
    always_comb
    begin
        q[0] = ~row_bits;
        for (int i = 1; i < NSTEP; i++)
        begin
            q[i] = q[i-1] & (q[i-1] << (1 << (i - 1)));
        end
        acc         = '0;
        acc_started = 1'b0;
        for (int i = 0; i < NSTEP; i++)
        begin
            if (req_len_reg[i])
            begin
                acc         = acc_started ? (q[i] & (acc << (1 << i))) : q[i];
                acc_started = 1'b1;
            end
        end
        for (int k = 0; k < NCOL; k++)
        begin
            win[k] = acc[k] && (CIU_W'(k) < nc);
        end
    end

    // Lowest run end wins: it is also the lowest start
    always_comb
    begin
        end_col = '0;
        for (int k = NCOL - 1; k >= 0; k--)
        begin
            if (win2_reg[k])
            begin
                end_col = CW'(k);
            end
        end
    end

    assign start_col = CIU_W'(end_col) + CIU_W'(1) - req_len_reg;

    always_comb
    begin
        for (int k = 0; k < NCOL; k++)
        begin
            run_mask[k] = (CIU_W'(k) >= start_col) && (CIU_W'(k) <= CIU_W'(end_col));
            mark_bit[k] = (CIU_W'(k) == {1'b0, req_col_reg});
        end
    end

    // Pool counter and grant capture
    assign pool_inc = {1'b0, next_pool_reg} + PCNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_pool_reg <= '0;
        end
        else if (cmd.alloc_wr)
        begin
            next_pool_reg <= (pool_inc >= eff_pools) ? '0 : pool_inc[POOL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.alloc_wr)
        begin
            g_row_reg  <= row2_reg[ROW_W-1:0];
            g_col_reg  <= start_col[COL_W-1:0];
            g_pool_reg <= next_pool_reg;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            status_reg <= cmd.code;
            if (cmd.code == STAT_PLACED)
            begin
                grant_row_reg <= g_row_reg;
                grant_col_reg <= g_col_reg;
                pool_reg      <= g_pool_reg;
            end
            else
            begin
                grant_row_reg <= '0;
                grant_col_reg <= '0;
                pool_reg      <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign grant_row = grant_row_reg;
    assign grant_col = grant_col_reg;
    assign pool      = pool_reg;

    assign stat.req_alloc = req_type_reg;
    assign stat.mark_ok   = ({1'b0, req_row_reg} < nr) && ({1'b0, req_col_reg} < nc);
    assign stat.alloc_ok  = (req_len_reg != '0) && (req_len_reg <= nc) && (nr != '0);
    assign stat.hit       = v2_reg && (|win2_reg);
    assign stat.scan_done = (cnt_reg >= nr) && !v1_reg && !v2_reg;
    assign stat.out_busy  = out_valid_reg && out_stall;

endmodule

/* sv/ffsa_ctrl.sv */
// Controller state machine of the slot allocator: sequences mark,
// scan, write-back and result hand-off. Depends on ffsa_pkg.
module ffsa_ctrl
    import ffsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  ffsa_stat_t stat,
    output ffsa_cmd_t  cmd
);

    state_t  state_reg;
    state_t  state_next;
    status_t code_reg;
    status_t code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= STAT_NO_FIT;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.req_alloc)
                begin
                    if (stat.alloc_ok)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        code_next  = STAT_NO_FIT;
                        state_next = S_FINISH;
                    end
                end
                else if (stat.mark_ok)
                begin
                    state_next = S_MARK_WR;
                end
                else
                begin
                    code_next  = STAT_OUT_OF_RANGE;
                    state_next = S_FINISH;
                end
            end
            S_MARK_WR:
            begin
                code_next  = STAT_MARKED;
                state_next = S_FINISH;
            end
            S_SCAN:
            begin
                if (stat.hit)
                begin
                    state_next = S_ALLOC_WR;
                end
                else if (stat.scan_done)
                begin
                    code_next  = STAT_NO_FIT;
                    state_next = S_FINISH;
                end
            end
            S_ALLOC_WR:
            begin
                code_next  = STAT_PLACED;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        cmd.code = code_reg;
        in_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            S_DECODE:
            begin
                cmd.scan_start = stat.req_alloc && stat.alloc_ok;
                cmd.mark_rd    = !stat.req_alloc && stat.mark_ok;
            end
            S_MARK_WR:
            begin
                cmd.mark_wr = 1'b1;
            end
            S_SCAN:
            begin
                cmd.scan_run = !stat.hit;
            end
            S_ALLOC_WR:
            begin
                cmd.alloc_wr = 1'b1;
            end
            S_FINISH:
            begin
                cmd.load_out = !stat.out_busy;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

/* sv/first_fit_slot_allocator.sv */
// Top level of the first-fit slot allocator: controller plus datapath.
// Depends on ffsa_pkg, ffsa_ctrl, ffsa_dp (and ffsa_ram through ffsa_dp).
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  in       | in_valid / in_stall    | req_type, slot_row, slot_col, run_length
//  out      | out_valid / out_stall  | status, grant_row, grant_col, pool
//  cfg      | cfg_we                 | cfg_index, cfg_data
//
// A mark reads the addressed row and writes it back with the slot set. An allocate
// reads one bitmap row from the RAM per cycle, with the run search trailing the read
// by two stages, then writes the found run back.
// Reset clears the bitmap at once through per-row written flags; no clearing pass.
// A waiting result sits in the output register; a new transaction is taken
// while it waits, and only hand-off of the next result holds on out_stall.
module first_fit_slot_allocator
    import ffsa_pkg::*;
#(
    parameter int ROWS = 16,
    parameter int COLS = 128
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  req_type,
    input  logic [ROW_W-1:0]      slot_row,
    input  logic [COL_W-1:0]      slot_col,
    input  logic [LEN_W-1:0]      run_length,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output logic [ROW_W-1:0]      grant_row,
    output logic [COL_W-1:0]      grant_col,
    output logic [POOL_W-1:0]     pool
);

    ffsa_cmd_t  cmd;
    ffsa_stat_t stat;

    // Sequencer: decode, row scan, write-back, result hand-off
    ffsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Bitmap, run search, pool counter and result register
    ffsa_dp #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_type   (req_type),
        .slot_row   (slot_row),
        .slot_col   (slot_col),
        .run_length (run_length),
        .cmd        (cmd),
        .stat       (stat),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .status     (status),
        .grant_row  (grant_row),
        .grant_col  (grant_col),
        .pool       (pool)
    );

    // One transaction in flight: after an accept, hold off the next one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second transaction accepted while one is in flight");

    // Never overwrite a result that is still waiting for the consumer
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(out_valid && out_stall))
        else $error("result register overwritten under stall");

    // A run is written back only after the scan found a fit
    a_alloc_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc_wr |-> $past(stat.hit))
        else $error("allocate write-back without a hit");

    // A fresh scan starts with an empty pipeline
    a_scan_clean: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_start |=> !stat.hit)
        else $error("stale hit after scan start");

endmodule

/* tb/tb.sv */
// Self-checking bench for first_fit_slot_allocator: a directed table, then random phases.
// Requests are checked against a first-fit model of the slot bitmap and the pool pointer.
// Depends on ffsa_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module tb;
    import ffsa_pkg::*;

    localparam int ROWS          = 16;
    localparam int COLS          = 128;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 30;
    localparam int NUM_PHASES    = 15;
    localparam int PHASE_ITEMS   = 110;
    localparam int DIR_ROWS      = 37;

    localparam logic REQ_MARK  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [ROW_W-1:0]   slot_row;
        logic [COL_W-1:0]   slot_col;
        logic [LEN_W-1:0]   run_length;
    } slot_req_t;

    typedef struct packed {
        status_t            status;
        logic [ROW_W-1:0]   grant_row;
        logic [COL_W-1:0]   grant_col;
        logic [POOL_W-1:0]  pool;
    } slot_result_t;

    // ROW_REQ rows are predicted, ROW_CHK rows carry their answer, ROW_CFG rows write a register
    typedef enum logic [1:0] {
        ROW_REQ,
        ROW_CHK,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_IDX_W-1:0]    reg_idx;
        logic [CFG_DATA_W-1:0]   reg_val;
        slot_req_t               rq;
        slot_result_t            want;
    } dir_row_t;

    localparam slot_req_t    NO_REQ     = '{REQ_MARK, 4'd0, 7'd0, 8'd0};
    localparam slot_result_t ANY_RESULT = '{STAT_PLACED, 4'd0, 7'd0, 6'd0};

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = CFG_ROWS_IN_USE;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic                  req_type   = REQ_MARK;
    logic [ROW_W-1:0]      slot_row   = '0;
    logic [COL_W-1:0]      slot_col   = '0;
    logic [LEN_W-1:0]      run_length = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic [1:0]            status;
    logic [ROW_W-1:0]      grant_row;
    logic [COL_W-1:0]      grant_col;
    logic [POOL_W-1:0]     pool;

    // Model state: occupancy bitmap, pool pointer and register copies
    logic [COLS-1:0]   slot_map [ROWS];
    int                pool_ptr;
    logic [RIU_W-1:0]  rows_reg;
    logic [CIU_W-1:0]  cols_reg;
    logic [PCNT_W-1:0] pools_reg;

    slot_result_t alloc_outcomes [$];
    slot_result_t head;
    dir_row_t     dir_table [DIR_ROWS];

    int fail_count = 0;
    int cycle_count = 0;
    int stall_run = 0;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;

    first_fit_slot_allocator #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .slot_row   (slot_row),
        .slot_col   (slot_col),
        .run_length (run_length),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .grant_row  (grant_row),
        .grant_col  (grant_col),
        .pool       (pool)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Effective sizes: registers past the array size clamp to it, a zero pool count acts as one
    function automatic int eff_rows();
        return (rows_reg < ROWS) ? int'(rows_reg) : ROWS;
    endfunction

    function automatic int eff_cols();
        return (cols_reg < COLS) ? int'(cols_reg) : COLS;
    endfunction

    function automatic int eff_pools();
        if (pools_reg == 0)
            return 1;
        return (pools_reg > MAX_POOLS) ? int'(MAX_POOLS) : int'(pools_reg);
    endfunction

    // First-fit prediction: apply one request to the bitmap and return its outcome
    function automatic slot_result_t first_fit_outcome(input slot_req_t rq);
        slot_result_t res;
        int           nr;
        int           nc;
        int           run;
        int           first_col;
        int           next;
        bit           found;

        res       = ANY_RESULT;
        nr        = eff_rows();
        nc        = eff_cols();
        found     = 1'b0;
        first_col = 0;

        if (rq.req_type == REQ_MARK) begin
            // an already occupied slot still reports marked
            if (rq.slot_row < nr && rq.slot_col < nc) begin
                slot_map[rq.slot_row][rq.slot_col] = 1'b1;
                res.status = STAT_MARKED;
            end
            else
                res.status = STAT_OUT_OF_RANGE;
            return res;
        end

        res.status = STAT_NO_FIT;
        if (rq.run_length == 0 || rq.run_length > nc)
            return res;

        for (int r = 0; r < nr && !found; r++) begin
            run = 0;
            for (int c = 0; c < nc && !found; c++) begin
                if (slot_map[r][c])
                    run = 0;
                else begin
                    run++;
                    if (run == rq.run_length) begin
                        found     = 1'b1;
                        first_col = c + 1 - run;
                        for (int k = first_col; k <= c; k++)
                            slot_map[r][k] = 1'b1;
                        res.status    = STAT_PLACED;
                        res.grant_row = r[ROW_W-1:0];
                        res.grant_col = first_col[COL_W-1:0];
                        res.pool      = pool_ptr[POOL_W-1:0];
                        // a pointer left above a lowered count is granted as is, then wraps
                        next     = pool_ptr + 1;
                        pool_ptr = (next >= eff_pools()) ? 0 : next;
                    end
                end
            end
        end
        return res;
    endfunction

    // Idle length: mostly none, some short, a few long
    function automatic int idle_span(input int long_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 100 - 25 - long_pct)
            return 0;
        if (pick < 100 - long_pct)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Random request: mostly allocations of short runs, marks mostly inside the sizes in use
    function automatic slot_req_t random_request();
        slot_req_t rq;
        int        pick;
        int        len_pick;
        int        nr;
        int        nc;

        nr            = eff_rows();
        nc            = eff_cols();
        rq.slot_row   = ROW_W'($urandom);
        rq.slot_col   = COL_W'($urandom);
        rq.run_length = LEN_W'($urandom);
        pick          = $urandom_range(0, 99);
        if (pick < 58) begin
            rq.req_type = REQ_ALLOC;
            len_pick    = $urandom_range(0, 99);
            if (len_pick < 60)
                rq.run_length = LEN_W'($urandom_range(1, 4));
            else if (len_pick < 80)
                rq.run_length = LEN_W'($urandom_range(5, 16));
            else if (len_pick < 86)
                rq.run_length = LEN_W'($urandom_range(17, 128));
            else if (len_pick < 90)
                rq.run_length = LEN_W'(nc);             // a whole row
            else if (len_pick < 95)
                rq.run_length = LEN_W'($urandom_range(129, 255));
            else
                rq.run_length = '0;
        end
        else begin
            rq.req_type = REQ_MARK;
            if (pick < 88 && nr > 0 && nc > 0) begin
                rq.slot_row = ROW_W'($urandom_range(0, nr - 1));
                rq.slot_col = COL_W'($urandom_range(0, nc - 1));
            end
        end
        return rq;
    endfunction

    // Present one transaction, hold it until taken, then record its outcome
    task automatic offer(input slot_req_t rq, input bit typed, input slot_result_t typed_res);
        slot_result_t predicted;
        int           gap;

        in_valid   <= 1'b1;
        req_type   <= rq.req_type;
        slot_row   <= rq.slot_row;
        slot_col   <= rq.slot_col;
        run_length <= rq.run_length;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = first_fit_outcome(rq);
        alloc_outcomes.push_back(typed ? typed_res : predicted);
        gap = tx_quiet ? 0 : idle_span(5);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every outcome is in and the block has gone quiet
    task automatic drain();
        in_valid <= 1'b0;
        while (alloc_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; the caller lowers cfg_we after the last of a burst
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_ROWS_IN_USE: rows_reg  = val[RIU_W-1:0];
            CFG_COLS_IN_USE: cols_reg  = val[CIU_W-1:0];
            CFG_POOL_COUNT:  pools_reg = val[PCNT_W-1:0];
            default: ;
        endcase
    endtask

    // Receiver back-pressure; no new stall run starts during quiet phases
    always @(posedge clk)
    begin
        if (stall_run == 0 && !rx_quiet)
            stall_run = idle_span(2);
        out_stall <= (stall_run != 0);
        if (stall_run != 0)
            stall_run = stall_run - 1;
    end

    // Check every result handed off against the oldest outstanding outcome
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) begin
            if (alloc_outcomes.size() == 0) begin
                $display("%0t: result with nothing outstanding: status %0d row %0d col %0d pool %0d",
                         $time, status, grant_row, grant_col, pool);
                fail_count++;
            end
            else begin
                head = alloc_outcomes.pop_front();
                if (status !== head.status) begin
                    $display("%0t: status expected %0d got %0d", $time, head.status, status);
                    fail_count++;
                end
                if (grant_row !== head.grant_row) begin
                    $display("%0t: grant_row expected %0d got %0d",
                             $time, head.grant_row, grant_row);
                    fail_count++;
                end
                if (grant_col !== head.grant_col) begin
                    $display("%0t: grant_col expected %0d got %0d",
                             $time, head.grant_col, grant_col);
                    fail_count++;
                end
                if (pool !== head.pool) begin
                    $display("%0t: pool expected %0d got %0d", $time, head.pool, pool);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d outcomes still outstanding", $time,
                     alloc_outcomes.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] rows_val;
        logic [CFG_DATA_W-1:0] cols_val;
        logic [CFG_DATA_W-1:0] pool_val;
        bit                    in_cfg;

        // Directed table. Row kinds: predicted request, request with its answer typed in,
        // register write. The bitmap carries over from row to row.
        dir_table = '{
            // reset sizes: whole row, zero length, oversize run
            '{ROW_CHK, CFG_ROWS_IN_USE, 8'h00, '{REQ_ALLOC, 4'd0, 7'd0, 8'd128},
              '{STAT_PLACED, 4'd0, 7'd0, 6'd0}},
            '{ROW_CHK, CFG_ROWS_IN_USE, 8'h00, '{REQ_ALLOC, 4'd0, 7'd0, 8'd0},
              '{STAT_NO_FIT, 4'd0, 7'd0, 6'd0}},
            '{ROW_CHK, CFG_ROWS_IN_USE, 8'h00, '{REQ_ALLOC, 4'd15, 7'd127, 8'd255},
              '{STAT_NO_FIT, 4'd0, 7'd0, 6'd0}},
            // mark an occupied slot, then block the end of row 1
            '{ROW_CHK, CFG_ROWS_IN_USE, 8'h00, '{REQ_MARK, 4'd0, 7'd5, 8'd255},
              '{STAT_MARKED, 4'd0, 7'd0, 6'd0}},
            '{ROW_CHK, CFG_ROWS_IN_USE, 8'h00, '{REQ_MARK, 4'd1, 7'd127, 8'd0},
              '{STAT_MARKED, 4'd0, 7'd0, 6'd0}},
            '{ROW_CHK, CFG_ROWS_IN_USE, 8'h00, '{REQ_ALLOC, 4'd0, 7'd0, 8'd128},
              '{STAT_PLACED, 4'd2, 7'd0, 6'd0}},
            '{ROW_CHK, CFG_ROWS_IN_USE, 8'h00, '{REQ_ALLOC, 4'd0, 7'd0, 8'd127},
              '{STAT_PLACED, 4'd1, 7'd0, 6'd0}},
            // zero rows in use, written with the upper data bits set
            '{ROW_CFG, CFG_ROWS_IN_USE, 8'hE0, NO_REQ, ANY_RESULT},
            '{ROW_CHK, CFG_ROWS_IN_USE, 8'h00, '{REQ_MARK, 4'd0, 7'd0, 8'd0},
              '{STAT_OUT_OF_RANGE, 4'd0, 7'd0, 6'd0}},
            '{ROW_CHK, CFG_ROWS_IN_USE, 8'h00, '{REQ_ALLOC, 4'd0, 7'd0, 8'd1},
              '{STAT_NO_FIT, 4'd0, 7'd0, 6'd0}},
            // rows past the array size, zero columns in use
            '{ROW_CFG, CFG_ROWS_IN_USE, 8'h1F, NO_REQ, ANY_RESULT},
            '{ROW_CFG, CFG_COLS_IN_USE, 8'h00, NO_REQ, ANY_RESULT},
            '{ROW_CHK, CFG_ROWS_IN_USE, 8'h00, '{REQ_MARK, 4'd3, 7'd0, 8'd0},
              '{STAT_OUT_OF_RANGE, 4'd0, 7'd0, 6'd0}},
            '{ROW_CHK, CFG_ROWS_IN_USE, 8'h00, '{REQ_ALLOC, 4'd0, 7'd0, 8'd1},
              '{STAT_NO_FIT, 4'd0, 7'd0, 6'd0}},
            // columns past the array size, pool count of zero
            '{ROW_CFG, CFG_COLS_IN_USE, 8'hFF, NO_REQ, ANY_RESULT},
            '{ROW_CFG, CFG_POOL_COUNT,  8'h80, NO_REQ, ANY_RESULT},
            '{ROW_CHK, CFG_ROWS_IN_USE, 8'h00, '{REQ_MARK, 4'd15, 7'd127, 8'd0},
              '{STAT_MARKED, 4'd0, 7'd0, 6'd0}},
            '{ROW_CHK, CFG_ROWS_IN_USE, 8'h00, '{REQ_ALLOC, 4'd0, 7'd0, 8'd1},
              '{STAT_PLACED, 4'd3, 7'd0, 6'd0}},
            // pool count above the maximum, then lowered under the pointer
            '{ROW_CFG, CFG_POOL_COUNT,  8'h7F, NO_REQ, ANY_RESULT},
            '{ROW_REQ, CFG_ROWS_IN_USE, 8'h00, '{REQ_ALLOC, 4'd0, 7'd0, 8'd3}, ANY_RESULT},
            '{ROW_REQ, CFG_ROWS_IN_USE, 8'h00, '{REQ_ALLOC, 4'd0, 7'd0, 8'd3}, ANY_RESULT},
            '{ROW_CFG, CFG_POOL_COUNT,  8'h02, NO_REQ, ANY_RESULT},
            '{ROW_REQ, CFG_ROWS_IN_USE, 8'h00, '{REQ_ALLOC, 4'd0, 7'd0, 8'd2}, ANY_RESULT},
            '{ROW_REQ, CFG_ROWS_IN_USE, 8'h00, '{REQ_ALLOC, 4'd0, 7'd0, 8'd2}, ANY_RESULT},
            // a single slot in use
            '{ROW_CFG, CFG_ROWS_IN_USE, 8'h01, NO_REQ, ANY_RESULT},
            '{ROW_CFG, CFG_COLS_IN_USE, 8'h01, NO_REQ, ANY_RESULT},
            '{ROW_CHK, CFG_ROWS_IN_USE, 8'h00, '{REQ_MARK, 4'd0, 7'd1, 8'd0},
              '{STAT_OUT_OF_RANGE, 4'd0, 7'd0, 6'd0}},
            '{ROW_CHK, CFG_ROWS_IN_USE, 8'h00, '{REQ_MARK, 4'd1, 7'd0, 8'd0},
              '{STAT_OUT_OF_RANGE, 4'd0, 7'd0, 6'd0}},
            '{ROW_CHK, CFG_ROWS_IN_USE, 8'h00, '{REQ_ALLOC, 4'd0, 7'd0, 8'd1},
              '{STAT_NO_FIT, 4'd0, 7'd0, 6'd0}},
            '{ROW_CHK, CFG_ROWS_IN_USE, 8'h00, '{REQ_ALLOC, 4'd0, 7'd0, 8'd2},
              '{STAT_NO_FIT, 4'd0, 7'd0, 6'd0}},
            // back to full size, maximum pools, long runs through a fragmented row
            '{ROW_CFG, CFG_ROWS_IN_USE, 8'h10, NO_REQ, ANY_RESULT},
            '{ROW_CFG, CFG_COLS_IN_USE, 8'h80, NO_REQ, ANY_RESULT},
            '{ROW_CFG, CFG_POOL_COUNT,  8'h40, NO_REQ, ANY_RESULT},
            '{ROW_REQ, CFG_ROWS_IN_USE, 8'h00, '{REQ_ALLOC, 4'd0, 7'd0, 8'd128}, ANY_RESULT},
            '{ROW_REQ, CFG_ROWS_IN_USE, 8'h00, '{REQ_ALLOC, 4'd0, 7'd0, 8'd125}, ANY_RESULT},
            '{ROW_REQ, CFG_ROWS_IN_USE, 8'h00, '{REQ_ALLOC, 4'd0, 7'd0, 8'd117}, ANY_RESULT},
            '{ROW_REQ, CFG_ROWS_IN_USE, 8'h00, '{REQ_MARK, 4'd15, 7'd0, 8'd0}, ANY_RESULT}
        };

        // Model starts from the reset state
        for (int r = 0; r < ROWS; r++)
            slot_map[r] = '0;
        pool_ptr  = 0;
        rows_reg  = RIU_RESET;
        cols_reg  = CIU_RESET;
        pools_reg = PCNT_RESET;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Walk the directed table
        in_cfg = 1'b0;
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_table[i].kind == ROW_CFG) begin
                if (!in_cfg)
                    drain();
                write_reg(dir_table[i].reg_idx, dir_table[i].reg_val);
                in_cfg = 1'b1;
            end
            else begin
                if (in_cfg)
                    cfg_we <= 1'b0;
                in_cfg = 1'b0;
                offer(dir_table[i].rq, dir_table[i].kind == ROW_CHK, dir_table[i].want);
            end
        end

        // Random phases. The bitmap is never cleared, so widen the columns in use phase by
        // phase to keep fresh space coming; every phase boundary drains the block.
        for (int k = 0; k < NUM_PHASES; k++) begin
            if (k == 6)
                rows_val = 8'd0;
            else if (k == 10)
                rows_val = 8'd31;
            else if ($urandom_range(0, 3) == 0)
                rows_val = CFG_DATA_W'($urandom_range(1, 15));
            else
                rows_val = 8'd16;
            rows_val[7:5] = 3'($urandom_range(0, 7));

            if (k == 3)
                cols_val = 8'd1;
            else if (k == NUM_PHASES - 1)
                cols_val = 8'hFF;
            else
                cols_val = CFG_DATA_W'(8 * (k + 1) + $urandom_range(0, 7));

            case (k)
                0:       pool_val = 8'h40;
                2:       pool_val = 8'hFF;
                4:       pool_val = 8'h00;
                default: pool_val = CFG_DATA_W'($urandom_range(0, 1) ? $urandom_range(1, 8)
                                                                     : $urandom_range(1, 64));
            endcase
            if (k > 4)
                pool_val[7] = 1'($urandom_range(0, 1));

            drain();
            write_reg(CFG_ROWS_IN_USE, rows_val);
            write_reg(CFG_COLS_IN_USE, cols_val);
            write_reg(CFG_POOL_COUNT, pool_val);
            cfg_we <= 1'b0;

            // some phases run back to back on one side or both
            tx_quiet = (k % 4 == 1);
            rx_quiet = (k % 4 == 1) || (k % 4 == 2);

            for (int n = 0; n < PHASE_ITEMS; n++)
                offer(random_request(), 1'b0, ANY_RESULT);
        end

        drain();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
sv/ffsa_pkg.sv
sv/ffsa_ram.sv
sv/ffsa_dp.sv
sv/ffsa_ctrl.sv
sv/first_fit_slot_allocator.sv
tb/tb.sv
